>>> src/spq_pkg.sv
package spq_pkg;

  localparam int NUM_CLASSES = 8;
  localparam int CLASS_DEPTH = 256;

  localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PTR_W     = $clog2(CLASS_DEPTH);
  localparam int CNT_W     = $clog2(CLASS_DEPTH + 1);
  localparam int ADDR_W    = $clog2(NUM_CLASSES * CLASS_DEPTH);
  localparam int SUM_W     = 32;
  localparam int ID_W      = 16;
  localparam int PB_W      = 14;
  localparam int PRIO_W    = 8;
  localparam int CC_W      = 4;
  localparam int LIM_W     = 16;
  localparam int MEAN_W    = 14;
  localparam int THR_W     = 16;
  localparam int MODE_W    = 2;
  localparam int PROD_W    = LIM_W + MEAN_W;
  localparam int OUT_CLS_W = 3;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLASS_COUNT    = 3'd0,
    REG_BUFFER_LIMIT   = 3'd1,
    REG_MEAN_BYTES     = 3'd2,
    REG_MARK_THRESHOLD = 3'd3,
    REG_MARKING_MODE   = 3'd4
  } cfg_reg_t;

  localparam logic [STAT_W-1:0] STAT_ENQUEUED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DEQUEUED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

  localparam logic [MODE_W-1:0] MODE_PER_QUEUE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PER_PORT  = 2'd2;

  localparam logic CMD_ENQ = 1'b0;

  localparam logic [CC_W-1:0]   RST_CLASS_COUNT = 4'd8;
  localparam logic [LIM_W-1:0]  RST_LIMIT       = 16'd100;
  localparam logic [MEAN_W-1:0] RST_MEAN        = 14'd1500;
  localparam logic [THR_W-1:0]  RST_THRESHOLD   = 16'd65;
  localparam logic [MODE_W-1:0] RST_MODE        = MODE_PER_PORT;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  typedef struct packed {
    logic [CLS_W-1:0]  cls_max;
    logic [PROD_W-1:0] limit;
    logic [PROD_W-1:0] thr;
    logic [MODE_W-1:0] mode;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [PB_W-1:0] bytes;
    logic            ce;
  } desc_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    desc_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   id;
    logic [PB_W-1:0]   bytes;
    logic [PRIO_W-1:0] prio;
    logic              ect;
    logic              ce;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [ID_W-1:0]      id;
    logic [PB_W-1:0]      bytes;
    logic                 ce;
    logic [OUT_CLS_W-1:0] cls;
  } result_t;

  function automatic logic [OUT_CLS_W-1:0] cls_out(input logic [CLS_W-1:0] c);
    return OUT_CLS_W'(32'(c));
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (32'(p) + 1 >= CLASS_DEPTH) ? '0 : PTR_W'(32'(p) + 1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] c,
                                                  input logic [PTR_W-1:0] p);
    return ADDR_W'(32'(c) * CLASS_DEPTH + 32'(p));
  endfunction

endpackage

>>> src/spq_if.sv
interface spq_in_if;
  import spq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [ID_W-1:0]          packet_id;
  logic [PB_W-1:0]          packet_bytes;
  logic signed [PRIO_W-1:0] packet_priority;
  logic                     ect_in;
  logic                     ce_in;

  modport source (output valid, cmd, packet_id, packet_bytes, packet_priority, ect_in,
                  ce_in, input ready);
  modport sink (input valid, cmd, packet_id, packet_bytes, packet_priority, ect_in,
                ce_in, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [ID_W-1:0]      out_packet_id;
  logic [PB_W-1:0]      out_packet_bytes;
  logic                 ce_out;
  logic [OUT_CLS_W-1:0] class_index;

  modport source (output valid, status, out_packet_id, out_packet_bytes, ce_out,
                  class_index, input ready);
  modport sink (input valid, status, out_packet_id, out_packet_bytes, ce_out,
                class_index, output ready);
endinterface

>>> src/strict_priority_queue_ecn_core.sv
// strict priority descriptor queue with ECN marking
// in_ch carries one command word: cmd 0 enqueues the descriptor (packet_id,
// packet_bytes, packet_priority, ect_in, ce_in), cmd 1 dequeues one descriptor.
// every command returns exactly one word on out_ch: status enqueued, dropped,
// dequeued or empty, with the packet id, size, final CE mark and class.
// the cfg port writes class_count, buffer_limit_packets, mean_packet_bytes,
// mark_threshold and marking_mode (index 0 to 4); the user must do so only while
// the queue is idle, as the block does not enforce it. one command is in flight
// at a time. an enqueue or empty word goes from the EXEC state into the out_ch
// output register, a dequeue word through EXEC and READ; the next command is
// taken back in IDLE, and the extra READ state is the descriptor memory read.
// the per-class head, tail, count and byte counters are updated at most once per
// command, and each command makes at most one descriptor memory access.
// synchronous reset empties all classes and restores the default registers;
// descriptor memory contents are not cleared and need no clearing pass.
// when out_ch stalls, the result word holds in the output register and the
// next command is still accepted, but its result waits until the word is taken.
module strict_priority_queue_ecn_core (
  input  logic                          clk,
  input  logic                          rst_n,
  spq_in_if.sink                        in_ch,
  spq_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [spq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spq_pkg::CFG_DAT_W-1:0] cfg_data
);
  import spq_pkg::*;

  cfg_t     cfg;
  item_t    item;
  logic     item_ready;
  logic     out_free;
  logic     res_valid;
  result_t  res;
  ram_req_t ram_req;
  desc_t    rdata;
  logic     out_valid_r;
  result_t  res_r;

  spq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spq_desc_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  assign item.cmd   = in_ch.cmd;
  assign item.id    = in_ch.packet_id;
  assign item.bytes = in_ch.packet_bytes;
  assign item.prio  = in_ch.packet_priority;
  assign item.ect   = in_ch.ect_in;
  assign item.ce    = in_ch.ce_in;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (in_ch.valid),
    .item_ready (item_ready),
    .cfg        (cfg),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .ram_req    (ram_req),
    .rdata      (rdata)
  );

  assign in_ch.ready = item_ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = res_r.status;
  assign out_ch.out_packet_id    = res_r.id;
  assign out_ch.out_packet_bytes = res_r.bytes;
  assign out_ch.ce_out           = res_r.ce;
  assign out_ch.class_index      = res_r.cls;

endmodule

>>> src/spq_cfg.sv
module spq_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [spq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spq_pkg::CFG_DAT_W-1:0]   cfg_data,
  output spq_pkg::cfg_t                   cfg
);
  import spq_pkg::*;

  logic [CC_W-1:0]   class_count_r;
  logic [LIM_W-1:0]  limit_pk_r;
  logic [MEAN_W-1:0] mean_r;
  logic [THR_W-1:0]  thr_pk_r;
  logic [MODE_W-1:0] mode_r;
  cfg_t              cfg_r;
  cfg_t              cfg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r <= RST_CLASS_COUNT;
      limit_pk_r    <= RST_LIMIT;
      mean_r        <= RST_MEAN;
      thr_pk_r      <= RST_THRESHOLD;
      mode_r        <= RST_MODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLASS_COUNT:    class_count_r <= cfg_data[CC_W-1:0];
        REG_BUFFER_LIMIT:   limit_pk_r    <= cfg_data[LIM_W-1:0];
        REG_MEAN_BYTES:     mean_r        <= cfg_data[MEAN_W-1:0];
        REG_MARK_THRESHOLD: thr_pk_r      <= cfg_data[THR_W-1:0];
        REG_MARKING_MODE:   mode_r        <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // byte limits in registers so the products stay off the enqueue path
  always_comb begin
    cfg_nxt.limit = PROD_W'(limit_pk_r) * PROD_W'(mean_r);
    cfg_nxt.thr   = PROD_W'(thr_pk_r) * PROD_W'(mean_r);
    cfg_nxt.mode  = mode_r;
    if (class_count_r == '0) begin
      cfg_nxt.cls_max = '0;
    end else if (32'(class_count_r) > NUM_CLASSES) begin
      cfg_nxt.cls_max = CLS_W'(NUM_CLASSES - 1);
    end else begin
      cfg_nxt.cls_max = CLS_W'(32'(class_count_r) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cls_max <= CLS_W'(NUM_CLASSES - 1);
      cfg_r.limit   <= PROD_W'(RST_LIMIT) * PROD_W'(RST_MEAN);
      cfg_r.thr     <= PROD_W'(RST_THRESHOLD) * PROD_W'(RST_MEAN);
      cfg_r.mode    <= RST_MODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/spq_desc_ram.sv
module spq_desc_ram (
  input  logic              clk,
  input  spq_pkg::ram_req_t req,
  output spq_pkg::desc_t    rdata
);
  import spq_pkg::*;

  desc_t mem [NUM_CLASSES*CLASS_DEPTH];
  desc_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/spq_ctrl.sv
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::item_t    item,
  input  logic              item_valid,
  output logic              item_ready,
  input  spq_pkg::cfg_t     cfg,
  input  logic              out_free,
  output logic              res_valid,
  output spq_pkg::result_t  res,
  output spq_pkg::ram_req_t ram_req,
  input  spq_pkg::desc_t    rdata
);
  import spq_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  item_t            item_r;
  logic [CLS_W-1:0] sel_r;
  logic             sel_ld;

  logic [PTR_W-1:0] head_r    [NUM_CLASSES];
  logic [PTR_W-1:0] tail_r    [NUM_CLASSES];
  logic [CNT_W-1:0] entries_r [NUM_CLASSES];
  logic [SUM_W-1:0] cbytes_r  [NUM_CLASSES];
  logic [SUM_W-1:0] total_r;

  logic [CLS_W-1:0] enq_cls;
  logic [CLS_W-1:0] deq_sel;
  logic             deq_found;
  logic [CLS_W-1:0] acc_cls;
  logic [SUM_W:0]   sum_total;
  logic [SUM_W:0]   sum_class;
  logic             drop;
  logic             mark;
  logic             upd_enq;
  logic             upd_deq;

  // priority clamp, negative goes to the top class
  always_comb begin
    if (item_r.prio[PRIO_W-1]) begin
      enq_cls = '0;
    end else if (32'(item_r.prio[PRIO_W-2:0]) > 32'(cfg.cls_max)) begin
      enq_cls = cfg.cls_max;
    end else begin
      enq_cls = CLS_W'(32'(item_r.prio[PRIO_W-2:0]));
    end
  end

  // lowest non-empty class in use
  always_comb begin
    deq_found = 1'b0;
    deq_sel   = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (entries_r[i] != '0 && 32'(i) <= 32'(cfg.cls_max)) begin
        deq_found = 1'b1;
        deq_sel   = CLS_W'(i);
      end
    end
  end

  always_comb begin
    if (state_r == S_READ) begin
      acc_cls = sel_r;
    end else if (item_r.cmd == CMD_ENQ) begin
      acc_cls = enq_cls;
    end else begin
      acc_cls = deq_sel;
    end
  end

  assign sum_total = {1'b0, total_r} + (SUM_W+1)'(item_r.bytes);
  assign sum_class = {1'b0, cbytes_r[acc_cls]} + (SUM_W+1)'(item_r.bytes);
  assign drop = (sum_total > (SUM_W+1)'(cfg.limit)) ||
                (32'(entries_r[acc_cls]) >= CLASS_DEPTH);
  assign mark = item_r.ect &&
                ((cfg.mode == MODE_PER_QUEUE && sum_class > (SUM_W+1)'(cfg.thr)) ||
                 (cfg.mode == MODE_PER_PORT  && sum_total > (SUM_W+1)'(cfg.thr)));

  always_comb begin
    state_nxt  = state_r;
    item_ready = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    ram_req    = '0;
    upd_enq    = 1'b0;
    upd_deq    = 1'b0;
    sel_ld     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item_r.cmd == CMD_ENQ) begin
          if (out_free) begin
            res_valid = 1'b1;
            res.id    = item_r.id;
            res.bytes = item_r.bytes;
            res.cls   = cls_out(acc_cls);
            if (drop) begin
              res.status = STAT_DROPPED;
              res.ce     = item_r.ce;
            end else begin
              res.status          = STAT_ENQUEUED;
              res.ce              = item_r.ce | mark;
              upd_enq             = 1'b1;
              ram_req.we          = 1'b1;
              ram_req.waddr       = slot_addr(acc_cls, tail_r[acc_cls]);
              ram_req.wdata.id    = item_r.id;
              ram_req.wdata.bytes = item_r.bytes;
              ram_req.wdata.ce    = item_r.ce | mark;
            end
            state_nxt = S_IDLE;
          end
        end else if (!deq_found) begin
          if (out_free) begin
            res_valid  = 1'b1;
            res.status = STAT_EMPTY;
            state_nxt  = S_IDLE;
          end
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = slot_addr(acc_cls, head_r[acc_cls]);
          sel_ld        = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          res_valid  = 1'b1;
          res.status = STAT_DEQUEUED;
          res.id     = rdata.id;
          res.bytes  = rdata.bytes;
          res.ce     = rdata.ce;
          res.cls    = cls_out(acc_cls);
          upd_deq    = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_r <= item;
    end
    if (sel_ld) begin
      sel_r <= deq_sel;
    end
  end

  // per-class counters, read-modify-write at one class per command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i]    <= '0;
        tail_r[i]    <= '0;
        entries_r[i] <= '0;
        cbytes_r[i]  <= '0;
      end
      total_r <= '0;
    end else if (upd_enq) begin
      tail_r[acc_cls]    <= next_ptr(tail_r[acc_cls]);
      entries_r[acc_cls] <= entries_r[acc_cls] + CNT_W'(1);
      cbytes_r[acc_cls]  <= sum_class[SUM_W-1:0];
      total_r            <= sum_total[SUM_W-1:0];
    end else if (upd_deq) begin
      head_r[acc_cls]    <= next_ptr(head_r[acc_cls]);
      entries_r[acc_cls] <= entries_r[acc_cls] - CNT_W'(1);
      cbytes_r[acc_cls]  <= cbytes_r[acc_cls] - SUM_W'(rdata.bytes);
      total_r            <= total_r - SUM_W'(rdata.bytes);
    end
  end

endmodule

>>> src/spq_checker.sv
module spq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [spq_pkg::STAT_W-1:0]    status,
  input logic [spq_pkg::ID_W-1:0]      out_packet_id,
  input logic [spq_pkg::PB_W-1:0]      out_packet_bytes,
  input logic                          ce_out,
  input logic [spq_pkg::OUT_CLS_W-1:0] class_index
);
  import spq_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in flight");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_EMPTY |->
      out_packet_id == '0 && out_packet_bytes == '0 && !ce_out && class_index == '0)
    else $error("empty result carries nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

endmodule

bind strict_priority_queue_ecn_core spq_checker u_spq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .status           (out_ch.status),
  .out_packet_id    (out_ch.out_packet_id),
  .out_packet_bytes (out_ch.out_packet_bytes),
  .ce_out           (out_ch.ce_out),
  .class_index      (out_ch.class_index)
);
